FILE: src/sbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbs_pkg: shared types and constants for the strobe burst sequencer
// Request/response payloads, register map, function codes, timing constants.
// ----------------------------------------------------------------------------
package sbs_pkg;

   localparam int unsigned TICKS_PER_MS        = 1000;
   localparam int unsigned DELAY_FULL_SCALE_US = 49000;
   localparam int unsigned ADC_FULL            = 1023;

   // floor(s * FULL_SCALE / 1023) == (s * DELAY_RECIP) >> DELAY_RECIP_SHIFT
   // for every 10-bit s, since 2^shift exceeds 1023 * 1023.
   localparam int unsigned DELAY_RECIP_SHIFT = 21;
   localparam logic [63:0] DELAY_RECIP_WIDE  =
      ((64'(DELAY_FULL_SCALE_US) << DELAY_RECIP_SHIFT) + 64'(ADC_FULL - 1))
      / 64'(ADC_FULL);
   localparam int unsigned DELAY_RECIP_W = 28;
   localparam logic [DELAY_RECIP_W-1:0] DELAY_RECIP = DELAY_RECIP_WIDE[DELAY_RECIP_W-1:0];

   localparam logic [15:0] TICK_RELOAD = 16'(TICKS_PER_MS);

   localparam logic [1:0] FUNC_TICK      = 2'd0;
   localparam logic [1:0] FUNC_TRIGGER   = 2'd1;
   localparam logic [1:0] FUNC_DIRECTION = 2'd2;
   localparam logic [1:0] FUNC_POSITION  = 2'd3;

   localparam logic [2:0] CSR_PULSE_US       = 3'd0;
   localparam logic [2:0] CSR_GAP_MS         = 3'd1;
   localparam logic [2:0] CSR_STROBE_LIMIT   = 3'd2;
   localparam logic [2:0] CSR_MOTOR_CENTER   = 3'd3;
   localparam logic [2:0] CSR_MOTOR_DEADBAND = 3'd4;
   localparam logic [2:0] CSR_DELAY_DEADBAND = 3'd5;

   localparam logic [9:0] MOTOR_RESET = 10'd511;

   typedef struct packed {
      logic [1:0] func;
      logic [9:0] sample;
   } req_type;

   typedef struct packed {
      logic       strobe_level;
      logic [9:0] motor_compare;
      logic [3:0] pulses_done;
      logic       burst_active;
   } rsp_type;

   typedef struct packed {
      logic [15:0] pulse_us;
      logic [5:0]  gap_ms;
      logic [3:0]  strobe_limit;
      logic [9:0]  motor_center;
      logic [5:0]  motor_deadband;
      logic [9:0]  delay_deadband_us;
   } cfg_type;

endpackage

FILE: src/sbs_delay_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbs_delay_calc: position sample to start delay
// Scales the ADC count to microseconds by reciprocal multiply, then deadband.
// ----------------------------------------------------------------------------
module sbs_delay_calc (
   input  logic [9:0]  sample,
   input  logic [9:0]  deadband,
   output logic [15:0] delay
);
   import sbs_pkg::*;

   localparam int unsigned PROD_W = DELAY_RECIP_W + 10;

   logic [PROD_W-1:0] prod;
   logic [15:0]       scaled;

   assign prod   = PROD_W'(sample) * PROD_W'(DELAY_RECIP);
   assign scaled = prod[DELAY_RECIP_SHIFT +: 16];
   assign delay  = (scaled < 16'(deadband)) ? 16'd0 : scaled;

endmodule

FILE: src/sbs_motor_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbs_motor_calc: direction sample to motor compare value
// center + ((sample - center) >>> 3), deadband to zero, saturate to 0..1023.
// ----------------------------------------------------------------------------
module sbs_motor_calc (
   input  logic [9:0] sample,
   input  logic [9:0] center,
   input  logic [5:0] deadband,
   output logic [9:0] value
);
   logic signed [11:0] diff;
   logic signed [11:0] scaled;
   logic signed [11:0] db_pos;
   logic signed [11:0] offset;
   logic signed [11:0] sum;

   always_comb begin
      diff   = $signed({2'b00, sample}) - $signed({2'b00, center});
      scaled = diff >>> 3;
      db_pos = $signed({6'b000000, deadband});
      offset = ((scaled < db_pos) && (scaled > -db_pos)) ? 12'sd0 : scaled;
      sum    = $signed({2'b00, center}) + offset;
      if (sum < 12'sd0) begin
         value = 10'd0;
      end else if (sum > 12'sd1023) begin
         value = 10'd1023;
      end else begin
         value = sum[9:0];
      end
   end

endmodule

FILE: src/sbs_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbs_seq: burst timing and motor state
// Applies one request per step to the phase/counter state, returns new status.
// ----------------------------------------------------------------------------
module sbs_seq (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  sbs_pkg::req_type item,
   input  sbs_pkg::cfg_type cfg,
   output sbs_pkg::rsp_type status
);
   import sbs_pkg::*;

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_DELAY = 2'd1;
   localparam logic [1:0] PH_PULSE = 2'd2;
   localparam logic [1:0] PH_GAP   = 2'd3;

   logic [1:0]  phase_ff, phase_in;
   logic [15:0] tick_ff, tick_in;
   logic [5:0]  gap_ff, gap_in;
   logic [3:0]  count_ff, count_in;
   logic [15:0] delay_ff, delay_in;
   logic [9:0]  motor_ff, motor_in;
   logic        strobe_ff, strobe_in;

   logic [15:0] delay_calc;
   logic [9:0]  motor_calc;
   logic [3:0]  count_inc;

   sbs_delay_calc u_delay (
      .sample   (item.sample),
      .deadband (cfg.delay_deadband_us),
      .delay    (delay_calc)
   );

   sbs_motor_calc u_motor (
      .sample   (item.sample),
      .center   (cfg.motor_center),
      .deadband (cfg.motor_deadband),
      .value    (motor_calc)
   );

   assign count_inc = count_ff + 4'd1;

   always_comb begin
      phase_in  = phase_ff;
      tick_in   = tick_ff;
      gap_in    = gap_ff;
      count_in  = count_ff;
      delay_in  = delay_ff;
      motor_in  = motor_ff;
      strobe_in = strobe_ff;
      if (step) begin
         unique case (item.func)
            FUNC_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  if (tick_ff > 16'd1) begin
                     tick_in = tick_ff - 16'd1;
                  end else begin
                     tick_in = 16'd0;
                     unique case (phase_ff)
                        PH_DELAY: begin
                           strobe_in = 1'b1;
                           phase_in  = PH_PULSE;
                           tick_in   = cfg.pulse_us;
                        end
                        PH_PULSE: begin
                           strobe_in = 1'b0;
                           gap_in    = cfg.gap_ms;
                           count_in  = count_inc;
                           if (count_inc < cfg.strobe_limit) begin
                              phase_in = PH_GAP;
                              tick_in  = TICK_RELOAD;
                           end else begin
                              phase_in = PH_IDLE;
                           end
                        end
                        default: begin
                           if (gap_ff == 6'd0) begin
                              strobe_in = 1'b1;
                              phase_in  = PH_PULSE;
                              tick_in   = cfg.pulse_us;
                           end else begin
                              gap_in  = gap_ff - 6'd1;
                              tick_in = TICK_RELOAD;
                           end
                        end
                     endcase
                  end
               end
            end
            FUNC_TRIGGER: begin
               gap_in   = cfg.gap_ms;
               count_in = 4'd0;
               if (delay_ff != 16'd0) begin
                  phase_in = PH_DELAY;
                  tick_in  = delay_ff;
               end else begin
                  strobe_in = 1'b1;
                  phase_in  = PH_PULSE;
                  tick_in   = cfg.pulse_us;
               end
            end
            FUNC_DIRECTION: motor_in = motor_calc;
            default:        delay_in = delay_calc;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         tick_ff   <= 16'd0;
         gap_ff    <= 6'd0;
         count_ff  <= 4'd0;
         delay_ff  <= 16'd0;
         motor_ff  <= MOTOR_RESET;
         strobe_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         tick_ff   <= tick_in;
         gap_ff    <= gap_in;
         count_ff  <= count_in;
         delay_ff  <= delay_in;
         motor_ff  <= motor_in;
         strobe_ff <= strobe_in;
      end
   end

   always_comb begin
      status.strobe_level  = strobe_in;
      status.motor_compare = motor_in;
      status.pulses_done   = count_in;
      status.burst_active  = (phase_in != PH_IDLE);
   end

`ifndef SYNTH
   a_idle_dark: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> !strobe_ff)
      else $error("strobe on while idle");
   a_pulse_lit: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PULSE) |-> strobe_ff)
      else $error("strobe off during pulse");
   a_gap_dark: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_GAP) |-> !strobe_ff)
      else $error("strobe on during gap");
   a_no_step_hold: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff) && $stable(tick_ff) && $stable(count_ff))
      else $error("timing state moved without a request");
`endif

endmodule

FILE: src/strobe_burst_sequencer.sv
`timescale 1ns / 1ps
// Path: an accepted request is held in the input register, and its response is captured in the response register.
// Throughput: one request per cycle while responses are taken; the input and response registers decouple
// the two channels, so a stalled response still lets one request enter.
// Reset: synchronous, active high; clears both pipeline stages, the timing
// state and restores all control registers to their defaults.
// ----------------------------------------------------------------------------
// strobe_burst_sequencer: strobe pulse burst timer with motor compare hold
// Input register, one pass of sequencing logic, registered response.
// ----------------------------------------------------------------------------
module strobe_burst_sequencer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sbs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sbs_pkg::rsp_type rsp_data,
   input  logic             csr_wen,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_wdata
);
   import sbs_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type status;
   logic    advance;
   logic    accept;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_PULSE_US:       cfg_in.pulse_us          = csr_wdata;
            CSR_GAP_MS:         cfg_in.gap_ms            = csr_wdata[5:0];
            CSR_STROBE_LIMIT:   cfg_in.strobe_limit      = csr_wdata[3:0];
            CSR_MOTOR_CENTER:   cfg_in.motor_center      = csr_wdata[9:0];
            CSR_MOTOR_DEADBAND: cfg_in.motor_deadband    = csr_wdata[5:0];
            CSR_DELAY_DEADBAND: cfg_in.delay_deadband_us = csr_wdata[9:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_us          <= 16'd1000;
         cfg_ff.gap_ms            <= 6'd49;
         cfg_ff.strobe_limit      <= 4'd10;
         cfg_ff.motor_center      <= MOTOR_RESET;
         cfg_ff.motor_deadband    <= 6'd10;
         cfg_ff.delay_deadband_us <= 10'd10;
         in_valid_ff              <= 1'b0;
         rsp_valid_ff             <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= status;
      end
   end

   sbs_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg_ff),
      .status (status)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("request stalled with a free stage");
   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced request produced no response");
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      accept |=> in_valid_ff)
      else $error("accepted request lost at input stage");
`endif

endmodule
